/* src/pdvf_pkg.sv */
// Shared types and constants of the position derivative velocity filter.
package pdvf_pkg;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_ROUND,
    ST_DIV,
    ST_WAIT,
    ST_STORE,
    ST_OUT
  } state_t;

  // Configuration register indexes
  localparam logic [1:0] CFG_GAIN_LAST  = 2'd0;
  localparam logic [1:0] CFG_GAIN_OLDER = 2'd1;
  localparam logic [1:0] CFG_GAIN_STEP  = 2'd2;
  localparam logic [1:0] CFG_WARMUP     = 2'd3;

  // Multiply term selects
  localparam logic [1:0] TERM_LAST  = 2'd0;
  localparam logic [1:0] TERM_OLDER = 2'd1;
  localparam logic [1:0] TERM_STEP  = 2'd2;

  localparam int POS_W      = 32;
  localparam int VEL_W      = 32;
  localparam int INTERVAL_W = 20;
  localparam int ELAPSED_W  = 24;
  localparam int ACC_W      = 68;

  // Serial divider widths: |diff| * 1e6 plus half the divisor fits 53 bits
  localparam int DIV_NUM_W = 53;
  localparam int DIV_DEN_W = INTERVAL_W;

  localparam logic signed [31:0] US_PER_S = 32'sd1000000;

endpackage

/* src/position_derivative_velocity_filter_core.sv */
// Top level of the three-axis position derivative velocity filter.
//
// Input words arrive on the s_ channel: x, y, z positions and the interval
// since the previous sample. Each accepted word yields exactly one result
// word on the m_ channel: x, y, z velocities plus the filter mode and
// zero-interval flags. Gains and the warm-up time are set through the plain
// write port (cfg_we, cfg_index, cfg_data); the user must do so only while
// the block is idle, which the block itself does not enforce.
// The axes are worked one after another on a single 32x33 multiplier and
// a restoring divider. Steps from acceptance until m_tvalid rises:
//   filter mode:          3 axes x 3 multiply/accumulate, round, store
//   difference mode:      3 axes x 53-step division plus setup
//   zero interval:        3 stores and the output load
// s_tready is high only while the sequencer is idle, so a new word is
// taken only after the last one has been worked through to the output.
// A finished result waits in the output register; the next input word is
// taken meanwhile, and the sequencer holds its result until m_tready frees
// the register. Reset (rst, synchronous) clears positions, velocity
// history and elapsed time, and restores the default gains.
module position_derivative_velocity_filter_core #(
  parameter int FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // pos_x [31:0], pos_y [63:32], pos_z [95:64], interval_us [115:96], zero fill
  input  logic [119:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // vel_x [31:0], vel_y [63:32], vel_z [95:64]
  output logic [95:0]  m_tdata,
  // filter_mode [0], zero_interval [1]
  output logic [1:0]   m_tuser,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  localparam int ACC_W   = pdvf_pkg::ACC_W;
  localparam int POS_W   = pdvf_pkg::POS_W;
  localparam int VEL_W   = pdvf_pkg::VEL_W;
  localparam int INT_W   = pdvf_pkg::INTERVAL_W;
  localparam int EL_W    = pdvf_pkg::ELAPSED_W;
  localparam int NUM_W   = pdvf_pkg::DIV_NUM_W;
  localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) <<< (FRAC_BITS - 1);
  localparam logic [VEL_W-1:0] VEL_MAX = {1'b0, {(VEL_W-1){1'b1}}};
  localparam logic [VEL_W-1:0] VEL_MIN = {1'b1, {(VEL_W-1){1'b0}}};

  pdvf_pkg::state_t state, state_next;

  // Configuration registers
  logic signed [31:0] gain_last_velocity;
  logic signed [31:0] gain_older_velocity;
  logic signed [31:0] gain_position_step;
  logic [EL_W-1:0]    warmup_us;

  // Block state
  logic signed [POS_W-1:0] last_position [0:2];
  logic signed [VEL_W-1:0] vel_last      [0:2];
  logic signed [VEL_W-1:0] vel_older     [0:2];
  logic [EL_W-1:0]         elapsed_us;

  // Captured item and working registers
  logic signed [POS_W-1:0] in_pos   [0:2];
  logic [INT_W-1:0]        interval;
  logic                    mode;
  logic                    zero;
  logic [1:0]              axis;
  logic [1:0]              term;
  logic signed [64:0]      prod;
  logic signed [ACC_W-1:0] acc;
  logic [VEL_W-1:0]        res_vel  [0:2];

  // Divider link
  logic             div_start;
  logic             div_done;
  logic [NUM_W-1:0] div_dividend;
  logic [NUM_W-1:0] quotient;

  logic                    s_accept;
  logic [EL_W:0]           elapsed_sum;
  logic [EL_W-1:0]         elapsed_next;
  logic signed [POS_W:0]   diff;
  logic signed [31:0]      mul_a;
  logic signed [POS_W:0]   mul_b;
  logic                    acc_neg;
  logic [ACC_W-1:0]        acc_mag;
  logic [VEL_W-1:0]        vel_filt;
  logic [VEL_W-1:0]        vel_diff;
  logic [VEL_W-1:0]        vel_new;
  logic                    out_free;

  assign s_tready = (state == pdvf_pkg::ST_IDLE);
  assign s_accept = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  // Saturating elapsed time at acceptance
  assign elapsed_sum  = {1'b0, elapsed_us} + {{(EL_W + 1 - INT_W){1'b0}}, s_tdata[115:96]};
  assign elapsed_next = elapsed_sum[EL_W] ? {EL_W{1'b1}} : elapsed_sum[EL_W-1:0];

  // Position step of the current axis
  assign diff = {in_pos[axis][POS_W-1], in_pos[axis]}
              - {last_position[axis][POS_W-1], last_position[axis]};

  // Multiplier operand selection
  always_comb begin
    mul_a = pdvf_pkg::US_PER_S;
    mul_b = diff;
    if (mode) begin
      case (term)
        pdvf_pkg::TERM_LAST: begin
          mul_a = gain_last_velocity;
          mul_b = {vel_last[axis][VEL_W-1], vel_last[axis]};
        end
        pdvf_pkg::TERM_OLDER: begin
          mul_a = gain_older_velocity;
          mul_b = {vel_older[axis][VEL_W-1], vel_older[axis]};
        end
        default: begin
          mul_a = gain_position_step;
          mul_b = diff;
        end
      endcase
    end
  end

  // Magnitude of the scaled difference, rounded by half the interval
  assign acc_neg      = acc[ACC_W-1];
  assign acc_mag      = acc_neg ? ACC_W'(-acc) : ACC_W'(acc);
  assign div_dividend = {1'b0, acc_mag[NUM_W-2:0]}
                      + {{(NUM_W - INT_W + 1){1'b0}}, interval[INT_W-1:1]};

  // Saturate the rounded filter sum
  always_comb begin
    if ((acc[ACC_W-1:VEL_W-1] == '0) || (acc[ACC_W-1:VEL_W-1] == '1))
      vel_filt = acc[VEL_W-1:0];
    else if (acc[ACC_W-1])
      vel_filt = VEL_MIN;
    else
      vel_filt = VEL_MAX;
  end

  // Apply sign and saturate the quotient
  always_comb begin
    if (!acc_neg) begin
      vel_diff = (quotient[NUM_W-1:VEL_W-1] != '0) ? VEL_MAX : quotient[VEL_W-1:0];
    end else if ((quotient[NUM_W-1:VEL_W] != '0)
                 || (quotient[VEL_W-1] && (quotient[VEL_W-2:0] != '0))) begin
      vel_diff = VEL_MIN;
    end else begin
      vel_diff = -quotient[VEL_W-1:0];
    end
  end

  always_comb begin
    if (mode)
      vel_new = vel_filt;
    else if (zero)
      vel_new = '0;
    else
      vel_new = vel_diff;
  end

  // Next state and divider start
  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    case (state)
      pdvf_pkg::ST_IDLE: begin
        if (s_accept) begin
          if ((elapsed_next <= warmup_us) && (s_tdata[115:96] == '0))
            state_next = pdvf_pkg::ST_STORE;
          else
            state_next = pdvf_pkg::ST_MUL;
        end
      end
      pdvf_pkg::ST_MUL: state_next = pdvf_pkg::ST_ACC;
      pdvf_pkg::ST_ACC: begin
        if (term != pdvf_pkg::TERM_STEP)
          state_next = pdvf_pkg::ST_MUL;
        else if (mode)
          state_next = pdvf_pkg::ST_ROUND;
        else
          state_next = pdvf_pkg::ST_DIV;
      end
      pdvf_pkg::ST_ROUND: state_next = pdvf_pkg::ST_STORE;
      pdvf_pkg::ST_DIV: begin
        div_start  = 1'b1;
        state_next = pdvf_pkg::ST_WAIT;
      end
      pdvf_pkg::ST_WAIT: begin
        if (div_done)
          state_next = pdvf_pkg::ST_STORE;
      end
      pdvf_pkg::ST_STORE: begin
        if (axis == 2'd2)
          state_next = pdvf_pkg::ST_OUT;
        else if (zero)
          state_next = pdvf_pkg::ST_STORE;
        else
          state_next = pdvf_pkg::ST_MUL;
      end
      pdvf_pkg::ST_OUT: begin
        if (out_free)
          state_next = pdvf_pkg::ST_IDLE;
      end
      default: state_next = pdvf_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst)
      state <= pdvf_pkg::ST_IDLE;
    else
      state <= state_next;
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      gain_last_velocity  <= 32'sd21667;
      gain_older_velocity <= -32'sd1790;
      gain_position_step  <= 32'sd2339635;
      warmup_us           <= EL_W'(1000000);
    end else if (cfg_we) begin
      case (cfg_index)
        pdvf_pkg::CFG_GAIN_LAST:  gain_last_velocity  <= cfg_data;
        pdvf_pkg::CFG_GAIN_OLDER: gain_older_velocity <= cfg_data;
        pdvf_pkg::CFG_GAIN_STEP:  gain_position_step  <= cfg_data;
        pdvf_pkg::CFG_WARMUP:     warmup_us           <= cfg_data[EL_W-1:0];
        default: ;
      endcase
    end
  end

  // Elapsed time, positions and velocity history
  always_ff @(posedge clk) begin
    if (rst) begin
      elapsed_us <= '0;
      for (int i = 0; i < 3; i++) begin
        last_position[i] <= '0;
        vel_last[i]      <= '0;
        vel_older[i]     <= '0;
      end
    end else begin
      if (s_accept)
        elapsed_us <= elapsed_next;
      if (state == pdvf_pkg::ST_STORE) begin
        vel_older[axis]     <= vel_last[axis];
        vel_last[axis]      <= vel_new;
        last_position[axis] <= in_pos[axis];
      end
    end
  end

  // Capture the input word and step through axes and terms
  always_ff @(posedge clk) begin
    if (s_accept) begin
      in_pos[0] <= s_tdata[31:0];
      in_pos[1] <= s_tdata[63:32];
      in_pos[2] <= s_tdata[95:64];
      interval  <= s_tdata[115:96];
      mode      <= (elapsed_next > warmup_us);
      zero      <= (elapsed_next <= warmup_us) && (s_tdata[115:96] == '0);
      axis      <= 2'd0;
      term      <= (elapsed_next > warmup_us) ? pdvf_pkg::TERM_LAST : pdvf_pkg::TERM_STEP;
    end else begin
      case (state)
        pdvf_pkg::ST_ACC: begin
          if (term != pdvf_pkg::TERM_STEP)
            term <= term + 1'b1;
        end
        pdvf_pkg::ST_STORE: begin
          res_vel[axis] <= vel_new;
          if (axis != 2'd2)
            axis <= axis + 1'b1;
          term <= mode ? pdvf_pkg::TERM_LAST : pdvf_pkg::TERM_STEP;
        end
        default: ;
      endcase
    end
  end

  // Shared multiplier, registered, then accumulate and round
  always_ff @(posedge clk) begin
    case (state)
      pdvf_pkg::ST_MUL: prod <= mul_a * mul_b;
      pdvf_pkg::ST_ACC: begin
        if (!mode || (term == pdvf_pkg::TERM_LAST))
          acc <= ACC_W'(prod);
        else
          acc <= acc + ACC_W'(prod);
      end
      pdvf_pkg::ST_ROUND: acc <= (acc + HALF) >>> FRAC_BITS;
      default: ;
    endcase
  end

  pdvf_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (interval),
    .done     (div_done),
    .quotient (quotient)
  );

  // Output register: load when free, drop valid once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((state == pdvf_pkg::ST_OUT) && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == pdvf_pkg::ST_OUT) && out_free) begin
      m_tdata <= {res_vel[2], res_vel[1], res_vel[0]};
      m_tuser <= {zero, mode};
    end
  end

endmodule

/* src/pdvf_div.sv */
// Restoring serial divider, one quotient bit per cycle.
module pdvf_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [pdvf_pkg::DIV_NUM_W-1:0] dividend,
  input  logic [pdvf_pkg::DIV_DEN_W-1:0] divisor,
  output logic                           done,
  output logic [pdvf_pkg::DIV_NUM_W-1:0] quotient
);

  localparam int NUM_W = pdvf_pkg::DIV_NUM_W;
  localparam int DEN_W = pdvf_pkg::DIV_DEN_W;
  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [DEN_W-1:0] den;
  logic [DEN_W-1:0] rem;
  logic [NUM_W-1:0] quo;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [DEN_W+1:0] trial;

  // Trial subtract of the divisor from the shifted remainder
  assign trial = {1'b0, rem, quo[NUM_W-1]} - {2'b00, den};

  // Control: count the steps, pulse done after the last one
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NUM_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: shift dividend bits in, quotient bits out
  always_ff @(posedge clk) begin
    if (start) begin
      den <= divisor;
      rem <= '0;
      quo <= dividend;
    end else if (busy) begin
      if (trial[DEN_W+1]) begin
        rem <= {rem[DEN_W-2:0], quo[NUM_W-1]};
        quo <= {quo[NUM_W-2:0], 1'b0};
      end else begin
        rem <= trial[DEN_W-1:0];
        quo <= {quo[NUM_W-2:0], 1'b1};
      end
    end
  end

  assign quotient = quo;

endmodule
